// ===== hw/rtl/tfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tfd_pkg: shared definitions for the telemetry frame deframer
// Frame constants, result codes and the result item type.
// ----------------------------------------------------------------------------
package tfd_pkg;

   // Upper bound (exclusive) on the declared payload length
   localparam int LEN_LIMIT = 50;
   // Width of the internal length and position counters
   localparam int CNT_W = (LEN_LIMIT > 64) ? 8 : 6;

   localparam logic [7:0] HDR_FIRST    = 8'hAA;
   localparam logic [7:0] HDR_SECOND   = 8'hAF;
   localparam logic [7:0] FUNC_LIMIT   = 8'hF1;
   localparam logic [7:0] FUNC_READ    = 8'h02;
   localparam logic [7:0] READ_PID     = 8'h01;
   localparam logic [7:0] READ_VERSION = 8'hA0;
   localparam logic [7:0] GAIN_LOW     = 8'h10;
   localparam logic [7:0] GAIN_HIGH    = 8'h15;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_SUM_GOOD = 2'd1,
      KIND_SUM_BAD  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      REQ_NONE      = 2'd0,
      REQ_PID_READ  = 2'd1,
      REQ_VERSION   = 2'd2,
      REQ_GAIN_ACK  = 2'd3
   } request_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  func_code;
      logic [7:0]  data_byte;
      logic [5:0]  byte_index;
      logic [5:0]  frame_len;
      logic [7:0]  computed_sum;
      request_type request;
   } rsp_type;

endpackage

// ===== hw/rtl/tfd_req_if.sv =====
// ----------------------------------------------------------------------------
// tfd_req_if: received byte channel
// Valid/ready channel carrying one link byte per item.
// ----------------------------------------------------------------------------
interface tfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/tfd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tfd_rsp_if: deframer result channel
// Valid/ready channel carrying payload bytes and frame end results.
// ----------------------------------------------------------------------------
interface tfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] func_code;
   logic [7:0] data_byte;
   logic [5:0] byte_index;
   logic [5:0] frame_len;
   logic [7:0] computed_sum;
   logic [1:0] request;

   modport source (output valid, output kind, output func_code, output data_byte,
                   output byte_index, output frame_len, output computed_sum,
                   output request, input ready);
   modport sink   (input valid, input kind, input func_code, input data_byte,
                   input byte_index, input frame_len, input computed_sum,
                   input request, output ready);
endinterface

// ===== hw/rtl/tfd_parser.sv =====
// ----------------------------------------------------------------------------
// tfd_parser: frame parsing state machine
// Updates frame state on each accepted byte and forms at most one result.
// ----------------------------------------------------------------------------
module tfd_parser (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      rx_byte,
   output logic            res_valid,
   output tfd_pkg::rsp_type res
);

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_HDR2   = 3'd1,
      PH_FUNC   = 3'd2,
      PH_LEN    = 3'd3,
      PH_DATA   = 3'd4,
      PH_SUM    = 3'd5
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [tfd_pkg::CNT_W-1:0]   bytes_left_ff, bytes_left_in;
   logic [tfd_pkg::CNT_W-1:0]   payload_pos_ff, payload_pos_in;
   logic [7:0]                  frame_func_ff, frame_func_in;
   logic [tfd_pkg::CNT_W-1:0]   frame_length_ff, frame_length_in;
   logic [7:0]                  running_sum_ff, running_sum_in;
   logic [7:0]                  first_payload_ff, first_payload_in;

   logic [7:0] sum_add;
   logic       len_ok;
   logic       sum_good;

   assign sum_add  = running_sum_ff + rx_byte;
   assign len_ok   = {1'b0, rx_byte} < 9'(tfd_pkg::LEN_LIMIT);
   assign sum_good = (rx_byte == running_sum_ff);

   always_comb begin
      phase_in         = phase_ff;
      bytes_left_in    = bytes_left_ff;
      payload_pos_in   = payload_pos_ff;
      frame_func_in    = frame_func_ff;
      frame_length_in  = frame_length_ff;
      running_sum_in   = running_sum_ff;
      first_payload_in = first_payload_ff;
      res_valid        = 1'b0;
      res.kind         = tfd_pkg::KIND_PAYLOAD;
      res.func_code    = frame_func_ff;
      res.data_byte    = rx_byte;
      res.byte_index   = 6'(payload_pos_ff);
      res.frame_len    = 6'(frame_length_ff);
      res.computed_sum = sum_add;
      res.request      = tfd_pkg::REQ_NONE;

      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == tfd_pkg::HDR_FIRST) begin
               running_sum_in = rx_byte;
               phase_in       = PH_HDR2;
            end
         end
         PH_HDR2: begin
            if (rx_byte == tfd_pkg::HDR_SECOND) begin
               running_sum_in = sum_add;
               phase_in       = PH_FUNC;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_FUNC: begin
            if (rx_byte < tfd_pkg::FUNC_LIMIT) begin
               frame_func_in  = rx_byte;
               running_sum_in = sum_add;
               phase_in       = PH_LEN;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_LEN: begin
            if (len_ok) begin
               frame_length_in  = tfd_pkg::CNT_W'(rx_byte);
               bytes_left_in    = tfd_pkg::CNT_W'(rx_byte);
               payload_pos_in   = '0;
               first_payload_in = '0;
               running_sum_in   = sum_add;
               phase_in         = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_DATA: begin
            res_valid = 1'b1;
            if (payload_pos_ff == '0) begin
               first_payload_in = rx_byte;
            end
            running_sum_in = sum_add;
            payload_pos_in = payload_pos_ff + 1'b1;
            bytes_left_in  = bytes_left_ff - 1'b1;
            if (bytes_left_ff == tfd_pkg::CNT_W'(1)) begin
               phase_in = PH_SUM;
            end
         end
         PH_SUM: begin
            res_valid        = 1'b1;
            res.kind         = sum_good ? tfd_pkg::KIND_SUM_GOOD : tfd_pkg::KIND_SUM_BAD;
            res.byte_index   = '0;
            res.computed_sum = running_sum_ff;
            if (sum_good) begin
               if (frame_func_ff == tfd_pkg::FUNC_READ && frame_length_ff != '0) begin
                  if (first_payload_ff == tfd_pkg::READ_PID) begin
                     res.request = tfd_pkg::REQ_PID_READ;
                  end else if (first_payload_ff == tfd_pkg::READ_VERSION) begin
                     res.request = tfd_pkg::REQ_VERSION;
                  end
               end else if (frame_func_ff >= tfd_pkg::GAIN_LOW &&
                            frame_func_ff <= tfd_pkg::GAIN_HIGH) begin
                  res.request = tfd_pkg::REQ_GAIN_ACK;
               end
            end
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         bytes_left_ff    <= '0;
         payload_pos_ff   <= '0;
         frame_func_ff    <= '0;
         frame_length_ff  <= '0;
         running_sum_ff   <= '0;
         first_payload_ff <= '0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         bytes_left_ff    <= bytes_left_in;
         payload_pos_ff   <= payload_pos_in;
         frame_func_ff    <= frame_func_in;
         frame_length_ff  <= frame_length_in;
         running_sum_ff   <= running_sum_in;
         first_payload_ff <= first_payload_in;
      end
   end

endmodule

// ===== hw/rtl/tfd_out_buf.sv =====
// ----------------------------------------------------------------------------
// tfd_out_buf: result register with skid stage
// Holds results for the receiver; ready toward the sender is registered.
// ----------------------------------------------------------------------------
module tfd_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tfd_pkg::rsp_type push_data,
   output logic             in_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output tfd_pkg::rsp_type out_data
);

   logic             main_valid_ff;
   logic             skid_valid_ff;
   tfd_pkg::rsp_type main_ff;
   tfd_pkg::rsp_type skid_ff;
   logic             pop;

   assign pop       = main_valid_ff && out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // no push possible while the skid stage is full
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end
         main_valid_ff <= 1'b1;
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_ff <= push_data;
         end else begin
            main_ff <= push_data;
         end
      end
   end

endmodule

// ===== hw/rtl/telemetry_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// telemetry_frame_deframer: link byte frame parser
// Hunts for 0xAA 0xAF headers, checks the 8-bit sum, reports payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//  - req_chan carries one received link byte per item (rx_byte).
//  - rsp_chan gives one item per payload byte (kind payload, with its index and
//    the running sum) and one item per sum byte (kind sum good / sum bad, with
//    the computed sum and a request class). Header, function and length bytes
//    and any byte that breaks the format give no item.
//  - Results are registered in the output stage before they show on rsp_chan.
//  - Throughput: one byte per cycle while the skid register has room; the
//    parser state update is a single compare/add step in the accept cycle.
//  - Stall: a two-entry output stage (result register plus skid register)
//    absorbs one extra result; req_chan.ready drops only while the skid
//    register is full, so it does not depend on rsp_chan.ready combinationally.
//  - Reset (synchronous, active high): parser returns to hunting the first
//    header byte with all frame state cleared, and pending results are dropped.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer (
   input  logic     clock,
   input  logic     reset,
   tfd_req_if.sink   req_chan,
   tfd_rsp_if.source rsp_chan
);

   logic             accept;
   logic             res_valid;
   logic             buf_ready;
   tfd_pkg::rsp_type res;
   tfd_pkg::rsp_type out_data;

   // a byte is taken whenever the skid register has room
   assign req_chan.ready = buf_ready;
   assign accept         = req_chan.valid && buf_ready;

   tfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_chan.rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   tfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && res_valid),
      .push_data (res),
      .in_ready  (buf_ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data)
   );

   assign rsp_chan.kind         = out_data.kind;
   assign rsp_chan.func_code    = out_data.func_code;
   assign rsp_chan.data_byte    = out_data.data_byte;
   assign rsp_chan.byte_index   = out_data.byte_index;
   assign rsp_chan.frame_len    = out_data.frame_len;
   assign rsp_chan.computed_sum = out_data.computed_sum;
   assign rsp_chan.request      = out_data.request;

endmodule

// ===== hw/rtl/tfd_checker.sv =====
// ----------------------------------------------------------------------------
// tfd_checker: port level checks for the deframer
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module tfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_data_byte,
   input logic [5:0] rsp_byte_index,
   input logic [5:0] rsp_frame_len,
   input logic [1:0] rsp_request
);

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // payload items never carry a request class
   a_payload_no_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == tfd_pkg::KIND_PAYLOAD) |-> rsp_request == tfd_pkg::REQ_NONE)
      else $error("payload item with request class");

   // payload index stays inside the declared length
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == tfd_pkg::KIND_PAYLOAD) |-> rsp_byte_index < rsp_frame_len)
      else $error("payload index beyond frame length");

   // frame end items report index zero
   a_end_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == tfd_pkg::KIND_SUM_GOOD || rsp_kind == tfd_pkg::KIND_SUM_BAD))
      |-> rsp_byte_index == 6'd0)
      else $error("frame end with nonzero index");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data_byte)))
      else $error("stalled result changed");

endmodule

bind telemetry_frame_deframer tfd_checker u_tfd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_kind       (rsp_chan.kind),
   .rsp_data_byte  (rsp_chan.data_byte),
   .rsp_byte_index (rsp_chan.byte_index),
   .rsp_frame_len  (rsp_chan.frame_len),
   .rsp_request    (rsp_chan.request)
);
